>>> hdl/bcf_pkg.sv
// Package for the biquad cascade filter: field widths, fixed-point formats
// and the two coefficient sets in Q3.28.
// No dependencies; every other file of the block imports it.
package bcf_pkg;

	localparam int CHAN_W    = 2;
	localparam int SAMPLE_W  = 24;
	localparam int COEF_W    = 32;
	localparam int COEF_FRAC = 28;
	localparam int WORD_W    = 48;
	localparam int WORD_FRAC = 16;
	localparam int ACC_W     = 52;
	localparam int HALF_W    = 24;
	localparam int PROD_W    = COEF_W + HALF_W + 1;
	localparam int TSH_W     = PROD_W - HALF_W;
	localparam int RND_W     = PROD_W - (COEF_FRAC - HALF_W);
	localparam int KINDS     = 2;
	localparam int MAX_SECT  = 2;
	localparam int NCOEF     = 5;

	typedef logic signed [COEF_W-1:0] coef_t;

	// Coefficient order inside one section.
	typedef enum logic [2:0] {
		C_B0 = 3'd0,
		C_B1 = 3'd1,
		C_B2 = 3'd2,
		C_A1 = 3'd3,
		C_A2 = 3'd4
	} coef_sel_t;

	// Decimal constant given in units of 1e-10, rounded to Q3.28 (halves away from zero).
	function automatic coef_t q28(input longint unsigned d);
		q28 = coef_t'((d * 64'd268435456 + 64'd5000000000) / 64'd10000000000);
	endfunction

	// Indexed by filter kind, section and coefficient (b0, b1, b2, a1, a2).
	localparam coef_t COEF [KINDS][MAX_SECT][NCOEF] = '{
		'{
			'{ q28(64'd9794827610), -q28(64'd6053536377), q28(64'd9794827610),
			  -q28(64'd6053536377), q28(64'd9589655220) },
			'{ q28(64'd9794827610), -q28(64'd6053536377), q28(64'd9794827610),
			  -q28(64'd6053536377), q28(64'd9589655220) }
		},
		'{
			'{ q28(64'd9363784800), -q28(64'd18727569600), q28(64'd9363784800),
			  -q28(64'd19597916900), q28(64'd9622701200) },
			'{ q28(64'd10000000000), -q28(64'd20000000000), q28(64'd10000000000),
			  -q28(64'd19088649800), q28(64'd9112790100) }
		}
	};

endpackage

>>> hdl/bcf_ifs.sv
// Valid/ready channel interfaces of the biquad cascade filter: the sample
// request channel and the filtered result channel.
// Depends on bcf_pkg for the field widths.
interface bcf_in_if;
	import bcf_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [CHAN_W-1:0]          channel;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink (input valid, input channel, input sample, output ready);
endinterface

interface bcf_out_if;
	import bcf_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [CHAN_W-1:0]          channel_out;
	logic signed [SAMPLE_W-1:0] filtered;
	logic                       saturated;

	modport source (output valid, output channel_out, output filtered, output saturated,
		input ready);
	modport sink (input valid, input channel_out, input filtered, input saturated,
		output ready);
endinterface

>>> hdl/biquad_cascade_filter_unit.sv
// Multi-channel two-section direct-form-II biquad cascade on one shared multiplier.
// Depends on bcf_pkg and on the interfaces in bcf_ifs.sv.
//
// Usage: a request on in_ch carries a 24-bit sample and its channel. It runs
// through SECTIONS biquad sections that keep two 48-bit delay words per
// channel and section. The result (channel echo, rounded and saturated sample,
// saturation flag) appears on out_ch. cfg_wen/cfg_wdata select the coefficient
// set: 0 notch, 1 band high-pass; write it only while the block is idle.
// Timing: in_ch.ready is high only while the sequencer is idle. After a
// request is taken, the sequencer runs each section (a delay-word read, then
// the multiply steps) and writes the result to the output register; only
// then does it return to idle and take the next request, so it cannot take a
// new sample before it is through with the last one. The pace is set by the
// single 32x25 multiplier: each section needs five coefficient products, each
// done as two half-word multiplies, followed by rounding, accumulation and
// saturation.
// Reset clears all delay words, selects the notch and empties the output
// register. A stalled receiver holds the result in the output register;
// one further request is processed meanwhile and waits in the final step
// until the output register frees up.
module biquad_cascade_filter_unit #(
	parameter int CHANNELS = 4,
	parameter int SECTIONS = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wen,
	input  logic cfg_wdata,
	bcf_in_if.sink    in_ch,
	bcf_out_if.source out_ch
);
	import bcf_pkg::*;

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH    = CHANNELS * SECTIONS;
	localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int STEP_W   = 4;
	localparam int Y_W      = ACC_W - WORD_FRAC;
	localparam int MOD_W    = 5;

	localparam logic [STEP_W-1:0] STEP_W_CLIP     = 4'd6;
	localparam logic [STEP_W-1:0] STEP_FIRST_ACC  = 4'd3;
	localparam logic [STEP_W-1:0] STEP_LAST_SUB   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_LAST_ACC   = 4'd11;
	localparam logic [STEP_W-1:0] STEP_DONE       = 4'd12;

	localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) <<< (COEF_FRAC - 1);
	localparam logic signed [ACC_W-1:0]  OUT_HALF  = ACC_W'(1) <<< (WORD_FRAC - 1);
	localparam logic signed [WORD_W-1:0] WORD_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] WORD_MIN  = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_LOAD  = 4'b0010,
		S_RUN   = 4'b0100,
		S_FINAL = 4'b1000
	} state_t;

	state_t                     state_q;
	logic                       kind_q;
	logic [CHAN_W-1:0]          chan_q;
	logic [CH_IDX_W-1:0]        slot_q;
	logic                       sec_q;
	logic [STEP_W-1:0]          step_q;
	logic                       sat_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [WORD_W-1:0]   w1_q;
	logic signed [WORD_W-1:0]   w2_q;
	logic signed [WORD_W-1:0]   w_q;
	logic signed [WORD_W-1:0]   d1_q [DEPTH];
	logic signed [WORD_W-1:0]   d2_q [DEPTH];
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [TSH_W-1:0]    t_q;
	logic signed [RND_W-1:0]    r_s2;

	logic                       out_valid_q;
	logic [CHAN_W-1:0]          out_chan_q;
	logic signed [SAMPLE_W-1:0] out_filt_q;
	logic                       out_sat_q;

	logic                       in_fire;
	logic [MOD_W-1:0]           chan_mod;
	logic [IDX_W-1:0]           idx;
	coef_sel_t                  coef_sel;
	logic signed [WORD_W-1:0]   word_op;
	coef_t                      coef_op;
	logic signed [HALF_W:0]     half_op;
	logic signed [PROD_W-1:0]   prod_c;
	logic                       acc_ovf;
	logic signed [WORD_W-1:0]   acc_clip;
	logic signed [Y_W-1:0]      y_full;
	logic                       y_ovf;
	logic signed [SAMPLE_W-1:0] y_clip;
	logic                       acc_step;
	logic                       last_sec;
	logic                       out_free;

	assign in_ch.ready        = (state_q == S_IDLE);
	assign in_fire            = in_ch.valid && in_ch.ready;
	assign out_ch.valid       = out_valid_q;
	assign out_ch.channel_out = out_chan_q;
	assign out_ch.filtered    = out_filt_q;
	assign out_ch.saturated   = out_sat_q;
	assign out_free           = !out_valid_q || out_ch.ready;
	assign last_sec           = (sec_q == 1'(SECTIONS - 1));

	// Channel folded into the configured channel count; the input is below four,
	// so at most three subtractions are needed.
	always_comb begin
		chan_mod = MOD_W'(in_ch.channel);
		for (int i = 0; i < 3; i++) begin
			if (chan_mod >= MOD_W'(CHANNELS)) begin
				chan_mod = chan_mod - MOD_W'(CHANNELS);
			end
		end
	end

	always_comb begin
		if (SECTIONS == 2) begin
			idx = IDX_W'({slot_q, sec_q});
		end else begin
			idx = IDX_W'(slot_q);
		end
	end

	// Operand schedule: a1*w1, a2*w2, b1*w1, b2*w2, b0*w, two steps each
	// (low half of the word first, then the high half).
	always_comb begin
		unique case (step_q[STEP_W-1:1])
			3'd0: begin
				coef_sel = C_A1;
				word_op  = w1_q;
			end
			3'd1: begin
				coef_sel = C_A2;
				word_op  = w2_q;
			end
			3'd2: begin
				coef_sel = C_B1;
				word_op  = w1_q;
			end
			3'd3: begin
				coef_sel = C_B2;
				word_op  = w2_q;
			end
			default: begin
				coef_sel = C_B0;
				word_op  = w_q;
			end
		endcase
	end

	assign coef_op = COEF[kind_q][sec_q][coef_sel];
	assign half_op = step_q[0] ? {word_op[WORD_W-1], word_op[WORD_W-1:HALF_W]}
	                           : {1'b0, word_op[HALF_W-1:0]};
	assign prod_c  = coef_op * half_op;

	assign acc_ovf  = (acc_q[ACC_W-1:WORD_W-1] != {(ACC_W-WORD_W+1){acc_q[WORD_W-1]}});
	assign acc_clip = acc_ovf ? (acc_q[ACC_W-1] ? WORD_MIN : WORD_MAX) : acc_q[WORD_W-1:0];
	assign acc_step = step_q[0] && (step_q >= STEP_FIRST_ACC) && (step_q <= STEP_LAST_ACC);

	assign y_full = Y_W'((acc_q + OUT_HALF) >>> WORD_FRAC);
	assign y_ovf  = (y_full[Y_W-1:SAMPLE_W-1] != {(Y_W-SAMPLE_W+1){y_full[SAMPLE_W-1]}});
	assign y_clip = y_ovf ? (y_full[Y_W-1] ? OUT_MIN : OUT_MAX) : y_full[SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= 1'b0;
		end else if (cfg_wen) begin
			kind_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sec_q   <= 1'b0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						sec_q   <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					step_q  <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_DONE) begin
						if (last_sec) begin
							state_q <= S_FINAL;
						end else begin
							sec_q   <= 1'b1;
							state_q <= S_LOAD;
						end
					end
				end
				S_FINAL: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				d1_q[i] <= '0;
				d2_q[i] <= '0;
			end
		end else if (state_q == S_RUN && step_q == STEP_DONE) begin
			d1_q[idx] <= w_q;
			d2_q[idx] <= w1_q;
		end
	end

	// Multiplier datapath: product, the low-half product rounded and shifted down
	// to the high half's weight, then the rounded product that the accumulator takes.
	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		r_s2    <= RND_W'((prod_s1 + PROD_W'(t_q)) >>> (COEF_FRAC - HALF_W));
		if (step_q[0]) begin
			t_q <= TSH_W'((prod_s1 + PROD_HALF) >>> HALF_W);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			chan_q <= in_ch.channel;
			slot_q <= CH_IDX_W'(chan_mod);
			acc_q  <= ACC_W'(in_ch.sample) <<< WORD_FRAC;
			sat_q  <= 1'b0;
		end else if (state_q == S_LOAD) begin
			w1_q <= d1_q[idx];
			w2_q <= d2_q[idx];
		end else if (state_q == S_RUN) begin
			if (acc_step) begin
				if (step_q <= STEP_LAST_SUB) begin
					acc_q <= acc_q - ACC_W'(r_s2);
				end else begin
					acc_q <= acc_q + ACC_W'(r_s2);
				end
			end else if (step_q == STEP_W_CLIP) begin
				w_q   <= acc_clip;
				acc_q <= '0;
				sat_q <= sat_q | acc_ovf;
			end else if (step_q == STEP_DONE) begin
				acc_q <= ACC_W'(acc_clip);
				sat_q <= sat_q | acc_ovf;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FINAL && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINAL && out_free) begin
			out_chan_q <= chan_q;
			out_filt_q <= y_clip;
			out_sat_q  <= sat_q | y_ovf;
		end
	end

endmodule
